// ===== hw/rtl/ffra_pkg.sv =====
// Shared types and codes for the first-fit region allocator.
`default_nettype none

package ffra_pkg;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_GAP    = 2'd1,
		ST_NO_SLOT   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] request_size;
		logic [15:0] release_offset;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] block_offset;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_region_allocator.sv =====
// Top level of the first-fit region allocator: sequencer, list walk and slot scan.
//
// Usage: raise start with a request on req while busy is low; the request is
// taken on that edge. mode selects allocate or free. The block answers with a
// one-cycle done strobe and rsp (status, block_offset); the receiver cannot
// stall it, so every result is a transfer on the cycle it is shown.
// Order of work after the accepting edge: the walk reads one list record per
// cycle. A free that matches a record, or a walk that ends empty, shows done
// straight from the walk. An allocate whose gap follows a record also waits
// for the lowest-free-slot scan (one slot per cycle beside the walk) and then
// passes a link state before done; a full table reports no slot once the scan
// has passed the last slot.
// One request at a time: busy is high from the accepting edge up to the edge
// that shows the result, and a new start may come in the done cycle.
// Config: cfg_data (pool size) is written on cfg_valid & cfg_ready, only while
// idle; every write rebuilds the empty list (start and end sentinel).
// Reset: pool size 4096, empty list, no result pending. Sentinels live in
// registers, so the record memory needs no clearing pass.
`default_nettype none

module first_fit_region_allocator #(
	parameter int NUM_SLOTS   = 32,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ffra_pkg::req_t req,
	output logic               done,
	output ffra_pkg::rsp_t     rsp,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [15:0]   cfg_data
);

	localparam int SW = $clog2(NUM_SLOTS);
	// Room for offset + length and a sign for the gap.
	localparam int EW = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;
	localparam logic [SW-1:0] SLOT_HEAD = SW'(0);
	localparam logic [SW-1:0] SLOT_TAIL = SW'(1);
	localparam logic [SW-1:0] SLOT_LAST = SW'(NUM_SLOTS - 1);
	localparam logic [NUM_SLOTS-1:0] BUSY_INIT = NUM_SLOTS'(2'b11);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_WAIT_SLOT,
		S_LINK
	} state_t;

	state_t                 state_q;
	ffra_pkg::req_t         req_q;
	logic [15:0]            pool_q;
	logic [SW-1:0]          link0_q;     // head sentinel's link
	logic [NUM_SLOTS-1:0]   slot_busy_q;
	logic [SW-1:0]          rd_idx_q;    // slot whose record is on the read port
	logic [SW-1:0]          cur_q;       // alloc: record before the gap; free: previous record
	logic [EW-1:0]          cur_end_q;
	logic [SW-1:0]          step_q;
	logic [SW-1:0]          next_q;      // successor of the chosen record
	logic [OFFSET_BITS-1:0] where_q;
	logic [SW-1:0]          scan_q;
	logic                   scan_done_q;
	logic                   scan_ok_q;
	logic                   done_q;
	ffra_pkg::rsp_t         rsp_q;

	// record memory ports
	logic                   we_rec;
	logic                   we_link;
	logic [SW-1:0]          waddr;
	logic [SW-1:0]          wlink;
	logic [SW-1:0]          raddr;
	logic [OFFSET_BITS-1:0] m_start;
	logic [15:0]            m_len;
	logic [SW-1:0]          m_link;

	// record under test, with the end sentinel overlaid
	logic                   at_tail;
	logic [OFFSET_BITS-1:0] eff_start;
	logic [15:0]            eff_len;
	logic [SW-1:0]          eff_link;
	logic signed [EW-1:0]   gap;
	logic                   gap_fit;
	logic                   free_hit;
	logic                   walk_alloc;
	logic                   walk_free;
	logic                   step_end;
	logic                   accept;
	logic                   cfg_wr;

	assign accept = start && (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_wr = cfg_valid && cfg_ready;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	assign at_tail   = (rd_idx_q == SLOT_TAIL);
	assign eff_start = at_tail ? OFFSET_BITS'(pool_q) : m_start;
	assign eff_len   = at_tail ? 16'd0 : m_len;
	assign eff_link  = at_tail ? SLOT_HEAD : m_link;

	assign gap = $signed(EW'(eff_start)) - $signed(cur_end_q);
	assign gap_fit = (gap >= $signed(EW'(req_q.request_size)));
	assign walk_alloc = (state_q == S_WALK) && (req_q.mode == ffra_pkg::MODE_ALLOC);
	assign walk_free  = (state_q == S_WALK) && (req_q.mode == ffra_pkg::MODE_FREE);
	assign free_hit = walk_free && !at_tail
		&& (EW'(eff_start) == EW'(req_q.release_offset));
	assign step_end = (step_q == SLOT_LAST);

	// memory control
	always_comb begin
		we_rec  = 1'b0;
		we_link = 1'b0;
		waddr   = cur_q;
		wlink   = eff_link;
		raddr   = SLOT_HEAD;
		case (state_q)
			S_IDLE: begin
				raddr = link0_q;
			end
			S_WALK: begin
				raddr = eff_link;
				// unlink: previous record takes the hit's successor
				if (free_hit && cur_q != SLOT_HEAD) begin
					we_link = 1'b1;
				end
			end
			S_WAIT_SLOT: begin
				waddr = scan_q;
				wlink = next_q;
				we_rec = scan_done_q && scan_ok_q;
			end
			S_LINK: begin
				wlink = scan_q;
				we_link = (cur_q != SLOT_HEAD);
			end
			default: begin
				raddr = SLOT_HEAD;
			end
		endcase
	end

	ffra_rec_mem #(
		.NUM_SLOTS  (NUM_SLOTS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_rec_mem (
		.clk    (clk),
		.we_rec (we_rec),
		.we_link(we_link),
		.waddr  (waddr),
		.wstart (where_q),
		.wlength(req_q.request_size),
		.wlink  (wlink),
		.raddr  (raddr),
		.rstart (m_start),
		.rlength(m_len),
		.rlink  (m_link)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pool_q      <= 16'd4096;
			link0_q     <= SLOT_TAIL;
			slot_busy_q <= BUSY_INIT;
			scan_done_q <= 1'b0;
			scan_ok_q   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;

			if (cfg_wr) begin
				pool_q      <= cfg_data;
				link0_q     <= SLOT_TAIL;
				slot_busy_q <= BUSY_INIT;
			end

			// lowest free slot scan, one slot a cycle
			if (state_q != S_IDLE && !scan_done_q) begin
				if (!slot_busy_q[scan_q]) begin
					scan_done_q <= 1'b1;
					scan_ok_q   <= 1'b1;
				end else if (scan_q == SLOT_LAST) begin
					scan_done_q <= 1'b1;
					scan_ok_q   <= 1'b0;
				end else begin
					scan_q <= scan_q + SW'(1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q       <= req;
						rd_idx_q    <= link0_q;
						cur_q       <= SLOT_HEAD;
						cur_end_q   <= '0;
						step_q      <= '0;
						scan_q      <= '0;
						scan_done_q <= 1'b0;
						scan_ok_q   <= 1'b0;
						state_q     <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_alloc && gap_fit) begin
						where_q <= cur_end_q[OFFSET_BITS-1:0];
						next_q  <= rd_idx_q;
						state_q <= S_WAIT_SLOT;
					end else if (free_hit) begin
						if (cur_q == SLOT_HEAD) begin
							link0_q <= eff_link;
						end
						slot_busy_q[rd_idx_q] <= 1'b0;
						rsp_q.status       <= ffra_pkg::ST_OK;
						rsp_q.block_offset <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (at_tail || step_end) begin
						// end of list or walk bound: nothing fits / nothing matches
						rsp_q.status       <= walk_alloc ? ffra_pkg::ST_NO_GAP
							: ffra_pkg::ST_NOT_FOUND;
						rsp_q.block_offset <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cur_q     <= rd_idx_q;
						cur_end_q <= EW'(eff_start) + EW'(eff_len);
						rd_idx_q  <= eff_link;
						step_q    <= step_q + SW'(1);
					end
				end
				S_WAIT_SLOT: begin
					if (scan_done_q) begin
						if (scan_ok_q) begin
							slot_busy_q[scan_q] <= 1'b1;
							state_q <= S_LINK;
						end else begin
							rsp_q.status       <= ffra_pkg::ST_NO_SLOT;
							rsp_q.block_offset <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_LINK: begin
					if (cur_q == SLOT_HEAD) begin
						link0_q <= scan_q;
					end
					rsp_q.status       <= ffra_pkg::ST_OK;
					rsp_q.block_offset <= 16'(where_q);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ffra_rec_mem.sv =====
// Block record storage: start, length and link per slot, one write and one registered read.
`default_nettype none

module ffra_rec_mem #(
	parameter int NUM_SLOTS   = 32,
	parameter int OFFSET_BITS = 16,
	localparam int SW = $clog2(NUM_SLOTS)
) (
	input  wire logic                   clk,
	input  wire logic                   we_rec,
	input  wire logic                   we_link,
	input  wire logic [SW-1:0]          waddr,
	input  wire logic [OFFSET_BITS-1:0] wstart,
	input  wire logic [15:0]            wlength,
	input  wire logic [SW-1:0]          wlink,
	input  wire logic [SW-1:0]          raddr,
	output logic      [OFFSET_BITS-1:0] rstart,
	output logic      [15:0]            rlength,
	output logic      [SW-1:0]          rlink
);

	logic [OFFSET_BITS-1:0] start_mem [NUM_SLOTS];
	logic [15:0]            length_mem [NUM_SLOTS];
	logic [SW-1:0]          link_mem [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (we_rec) begin
			start_mem[waddr]  <= wstart;
			length_mem[waddr] <= wlength;
		end
		if (we_rec || we_link) begin
			link_mem[waddr] <= wlink;
		end
		rstart  <= start_mem[raddr];
		rlength <= length_mem[raddr];
		rlink   <= link_mem[raddr];
	end

endmodule

`default_nettype wire
